>>> design/lbc_pkg.sv
// Shared types and constants for the LED blink-code controller.
// No dependencies; imported by led_blink_code_controller_top.
package lbc_pkg;

  localparam int CounterWidth = 16;
  localparam int PeriodWidth  = 16;
  localparam int CodeWidth    = 8;
  localparam int ToggleWidth  = CodeWidth + 1;
  localparam int CfgIdxWidth  = 2;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_MODE  = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;

  // mode codes
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_ON       = 3'd1;
  localparam logic [2:0] MODE_SLOW     = 3'd2;
  localparam logic [2:0] MODE_FAST     = 3'd3;
  localparam logic [2:0] MODE_ERROR    = 3'd4;
  localparam logic [2:0] MODE_PROGRESS = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_SLOW_PERIOD  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_FAST_PERIOD  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_PAUSE_PERIOD = 2'd2;

  localparam logic [PeriodWidth-1:0] SLOW_RESET  = 16'd500;
  localparam logic [PeriodWidth-1:0] FAST_RESET  = 16'd100;
  localparam logic [PeriodWidth-1:0] PAUSE_RESET = 16'd1000;

  localparam logic [CounterWidth-1:0] COUNT_MAX = {CounterWidth{1'b1}};

  typedef struct packed {
    logic [1:0]           op;
    logic [2:0]           mode;
    logic [CodeWidth-1:0] blink_code;
  } lbc_in_t;

  typedef struct packed {
    logic       led_lit;
    logic [2:0] mode_now;
  } lbc_out_t;

endpackage

>>> design/led_blink_code_controller_top.sv
// LED blink-code controller: each accepted word yields one result word; one word
// per clock while the input is not stalled. The state update is done in the accept
// cycle and the result lands in an output register backed by a one-entry skid
// register, so input is stalled only while both hold a word.
// Synchronous active-low reset: mode off, light dark, counters zero, periods
// 500/100/1000, no result pending.
module led_blink_code_controller_top
  import lbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lbc_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lbc_out_t               out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [PeriodWidth-1:0] cfg_data
);

  logic [PeriodWidth-1:0]  slow_period_r, fast_period_r, pause_period_r;
  logic [2:0]              mode_r, mode_nxt;
  logic [CounterWidth-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                    lit_r, lit_nxt;
  logic [ToggleWidth-1:0]  tcount_r, tcount_nxt;
  logic [CodeWidth-1:0]    burst_r, burst_nxt;

  logic                    out_valid_r, out_valid_nxt;
  lbc_out_t                out_data_r, out_data_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  lbc_out_t                skid_data_r, skid_data_nxt;

  logic                    in_acc, out_take;
  lbc_out_t                result;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // saturating tick count
  assign elapsed_inc = (elapsed_r != COUNT_MAX) ? elapsed_r + 1'b1 : elapsed_r;

  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    lit_nxt     = lit_r;
    tcount_nxt  = tcount_r;
    burst_nxt   = burst_r;
    if (in_acc) begin
      case (in_data.op)
        OP_TICK: begin
          elapsed_nxt = elapsed_inc;
          case (mode_r)
            MODE_OFF: lit_nxt = 1'b0;
            MODE_ON:  lit_nxt = 1'b1;
            MODE_SLOW: begin
              if (elapsed_inc >= slow_period_r) begin
                lit_nxt     = !lit_r;
                elapsed_nxt = '0;
              end
            end
            MODE_FAST, MODE_PROGRESS: begin
              if (elapsed_inc >= fast_period_r) begin
                lit_nxt     = !lit_r;
                elapsed_nxt = '0;
              end
            end
            MODE_ERROR: begin
              // blink burst of two toggles per code, then a pause with the light held
              if (burst_r != '0) begin
                if (tcount_r < {burst_r, 1'b0}) begin
                  if (elapsed_inc >= fast_period_r) begin
                    lit_nxt     = !lit_r;
                    elapsed_nxt = '0;
                    tcount_nxt  = tcount_r + 1'b1;
                  end
                end else if (elapsed_inc >= pause_period_r) begin
                  tcount_nxt  = '0;
                  elapsed_nxt = '0;
                end
              end
            end
            default: ;
          endcase
        end
        OP_MODE: begin
          // undefined mode codes leave everything alone
          if (in_data.mode <= MODE_PROGRESS) begin
            mode_nxt    = in_data.mode;
            elapsed_nxt = '0;
            tcount_nxt  = '0;
            if (in_data.mode == MODE_OFF) begin
              lit_nxt = 1'b0;
            end else if (in_data.mode == MODE_ON) begin
              lit_nxt = 1'b1;
            end
          end
        end
        OP_ERROR: begin
          burst_nxt   = in_data.blink_code;
          tcount_nxt  = '0;
          mode_nxt    = MODE_ERROR;
          elapsed_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  assign result.led_lit  = lit_nxt;
  assign result.mode_now = mode_nxt;

  // output register plus skid word
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      if (out_valid_r && out_stall) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r  <= SLOW_RESET;
      fast_period_r  <= FAST_RESET;
      pause_period_r <= PAUSE_RESET;
      mode_r         <= MODE_OFF;
      elapsed_r      <= '0;
      lit_r          <= 1'b0;
      tcount_r       <= '0;
      burst_r        <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOW_PERIOD:  slow_period_r  <= cfg_data;
          REG_FAST_PERIOD:  fast_period_r  <= cfg_data;
          REG_PAUSE_PERIOD: pause_period_r <= cfg_data;
          default: ;
        endcase
      end
      mode_r       <= mode_nxt;
      elapsed_r    <= elapsed_nxt;
      lit_r        <= lit_nxt;
      tcount_r     <= tcount_nxt;
      burst_r      <= burst_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

>>> sim/tb.sv
// Self-checking bench for led_blink_code_controller_top: random handshakes on
// both word channels, period register writes between phases, scoreboard check.
// Depends on lbc_pkg and the controller RTL only.
module tb;
  import lbc_pkg::*;

  localparam logic [1:0]             OP_UNDEFINED = 2'd3;
  localparam logic [2:0]             MODE_BAD_LO  = 3'd6;
  localparam logic [2:0]             MODE_BAD_HI  = 3'd7;
  localparam logic [CfgIdxWidth-1:0] REG_NONE     = 2'd3;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASE_WORDS = 60;
  localparam int REPORT_MAX  = 10;

  class blink_scoreboard;
    logic [PeriodWidth-1:0]  slow_period;
    logic [PeriodWidth-1:0]  fast_period;
    logic [PeriodWidth-1:0]  pause_period;
    logic [2:0]              mode_q;
    logic [CounterWidth-1:0] ticks_seen;
    logic                    lit;
    logic [ToggleWidth-1:0]  flips;
    logic [CodeWidth-1:0]    burst;
    lbc_out_t                expected_lights[$];
    int                      failures;

    function new();
      slow_period  = SLOW_RESET;
      fast_period  = FAST_RESET;
      pause_period = PAUSE_RESET;
      mode_q       = MODE_OFF;
      ticks_seen   = '0;
      lit          = 1'b0;
      flips        = '0;
      burst        = '0;
      failures     = 0;
    endfunction

    function void write_period(logic [CfgIdxWidth-1:0] idx, logic [PeriodWidth-1:0] value);
      case (idx)
        REG_SLOW_PERIOD:  slow_period = value;
        REG_FAST_PERIOD:  fast_period = value;
        REG_PAUSE_PERIOD: pause_period = value;
        default: ;
      endcase
    endfunction

    function void advance_tick();
      if (ticks_seen != COUNT_MAX) ticks_seen++;
      case (mode_q)
        MODE_OFF: lit = 1'b0;
        MODE_ON:  lit = 1'b1;
        MODE_SLOW: begin
          if (ticks_seen >= slow_period) begin
            lit = ~lit;
            ticks_seen = '0;
          end
        end
        MODE_FAST, MODE_PROGRESS: begin
          if (ticks_seen >= fast_period) begin
            lit = ~lit;
            ticks_seen = '0;
          end
        end
        MODE_ERROR: begin
          // blink 2*code toggles, then sit dark-or-lit through the pause
          if (burst != '0) begin
            if (flips < {burst, 1'b0}) begin
              if (ticks_seen >= fast_period) begin
                lit = ~lit;
                ticks_seen = '0;
                flips++;
              end
            end else if (ticks_seen >= pause_period) begin
              flips = '0;
              ticks_seen = '0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_word(lbc_in_t w);
      lbc_out_t e;
      case (w.op)
        OP_TICK: advance_tick();
        OP_MODE: begin
          if (w.mode <= MODE_PROGRESS) begin
            mode_q = w.mode;
            ticks_seen = '0;
            flips = '0;
            if (w.mode == MODE_OFF) lit = 1'b0;
            else if (w.mode == MODE_ON) lit = 1'b1;
          end
        end
        OP_ERROR: begin
          burst = w.blink_code;
          flips = '0;
          mode_q = MODE_ERROR;
          ticks_seen = '0;
        end
        default: ;
      endcase
      e.led_lit = lit;
      e.mode_now = mode_q;
      expected_lights.push_back(e);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_word(lbc_out_t got);
      lbc_out_t want;
      if (expected_lights.size() == 0) begin
        flag($sformatf("result word with none outstanding: led_lit=%0d mode_now=%0d",
                       got.led_lit, got.mode_now));
        return;
      end
      want = expected_lights.pop_front();
      if (got.led_lit !== want.led_lit)
        flag($sformatf("led_lit mismatch: expected %0d, actual %0d",
                       want.led_lit, got.led_lit));
      if (got.mode_now !== want.mode_now)
        flag($sformatf("mode_now mismatch: expected %0d, actual %0d",
                       want.mode_now, got.mode_now));
    endfunction

    function int pending();
      return expected_lights.size();
    endfunction

    function void flag_leftovers();
      if (expected_lights.size() != 0)
        flag($sformatf("%0d result words never arrived", expected_lights.size()));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  lbc_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  lbc_out_t               out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [PeriodWidth-1:0] cfg_data = '0;

  logic took_cfg, took_in, took_out;
  assign took_cfg = cfg_valid && cfg_ready;
  assign took_in  = in_valid && !in_stall;
  assign took_out = out_valid && !out_stall;

  blink_scoreboard sb;
  bit sender_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int useful_words = 0;

  led_blink_code_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: hold off a random number of cycles after each result word
  always @(posedge clk) begin
    if (took_out) hold_left = rx_quiet ? 0 : $urandom_range(0, 9);
    else if (hold_left > 0) hold_left--;
    out_stall <= (hold_left != 0);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (took_cfg) sb.write_period(cfg_index, cfg_data);
      if (took_in) sb.note_word(in_data);
      if (took_out) sb.check_word(out_data);
      if (took_cfg || took_in || took_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic lbc_in_t word_of(logic [1:0] op, logic [2:0] mode,
                                      logic [CodeWidth-1:0] code);
    lbc_in_t w;
    w.op = op;
    w.mode = mode;
    w.blink_code = code;
    return w;
  endfunction

  // leaves valid high on return; callers that stop sending must lower it
  task automatic put_word(input lbc_in_t w);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(w.op == OP_UNDEFINED || (w.op == OP_MODE && w.mode > MODE_PROGRESS)))
      useful_words++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_periods(input logic [PeriodWidth-1:0] slow_p, fast_p, pause_p,
                              input bit stray);
    logic [CfgIdxWidth-1:0] idx[4];
    logic [PeriodWidth-1:0] val[4];
    int n;
    idx = '{REG_SLOW_PERIOD, REG_FAST_PERIOD, REG_PAUSE_PERIOD, REG_NONE};
    val = '{slow_p, fast_p, pause_p, PeriodWidth'($urandom)};
    n = stray ? 4 : 3;
    drain_results();
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // an optional command followed by a run of ticks, with a little noise mixed in
  task automatic run_scene();
    int pick;
    int n;
    lbc_in_t w;
    sender_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 9);
    w = word_of(OP_TICK, 3'($urandom), 8'($urandom));
    if (pick <= 4) begin
      w.op = OP_MODE;
      w.mode = 3'($urandom_range(0, 5));
    end else if (pick <= 7) begin
      w.op = OP_ERROR;
      w.blink_code = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    end else if (pick == 8) begin
      w.op = OP_MODE;
      w.mode = $urandom_range(0, 1) ? MODE_BAD_LO : MODE_BAD_HI;
    end
    if (pick <= 8) put_word(w);
    n = $urandom_range(0, 30);
    repeat (n) begin
      w = word_of(OP_TICK, 3'($urandom), 8'($urandom));
      if ($urandom_range(0, 19) == 0) w.op = OP_UNDEFINED;
      put_word(w);
    end
    if ($urandom_range(0, 9) == 0) drain_results();
  endtask

  initial begin
    int target;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset periods: forced levels and ignored words
    put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_MODE, MODE_ON, 8'h00));
    put_word(word_of(OP_TICK, MODE_OFF, 8'hFF));
    put_word(word_of(OP_MODE, MODE_OFF, 8'h00));
    put_word(word_of(OP_MODE, MODE_BAD_LO, 8'h00));
    put_word(word_of(OP_MODE, MODE_BAD_HI, 8'hFF));
    put_word(word_of(OP_UNDEFINED, MODE_ON, 8'h01));

    // short periods so every blink mode and the burst pause show up quickly
    load_periods(16'd2, 16'd1, 16'd3, 1'b0);
    put_word(word_of(OP_MODE, MODE_SLOW, 8'h00));
    repeat (2) put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_MODE, MODE_FAST, 8'h00));
    put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_MODE, MODE_PROGRESS, 8'h00));
    put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_ERROR, MODE_OFF, 8'h00));
    repeat (2) put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_ERROR, MODE_OFF, 8'h01));
    repeat (6) put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_MODE, MODE_ERROR, 8'h00));
    put_word(word_of(OP_TICK, MODE_OFF, 8'h00));
    put_word(word_of(OP_ERROR, MODE_BAD_HI, 8'hFF));
    put_word(word_of(OP_TICK, MODE_OFF, 8'h00));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_periods(16'd0, 16'd0, 16'd0, 1'b1);
        1: load_periods(16'd1, 16'd1, 16'd1, 1'b0);
        2: load_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        3: load_periods(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                        16'($urandom_range(1, 6)), 1'b0);
        4: load_periods(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                        16'($urandom_range(1, 20)), 1'b1);
        default: load_periods(16'($urandom), 16'($urandom_range(1, 3)),
                              16'($urandom_range(1, 8)), 1'b1);
      endcase
      target = useful_words + PHASE_WORDS;
      while (useful_words < target) run_scene();
    end

    drain_results();
    repeat (10) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
design/lbc_pkg.sv
design/led_blink_code_controller_top.sv
sim/tb.sv
